/* hw/rtl/fsktm_pkg.sv */
`timescale 1ns / 1ps

package fsktm_pkg;

	localparam int QUEUE_DEPTH_DEF    = 64;
	localparam int SINE_ADDR_BITS_DEF = 10;

	localparam int REQ_W      = 2;
	localparam int BYTE_W     = 8;
	localparam int INC_W      = 31;
	localparam int SPS_W      = 16;
	localparam int AMP_W      = 15;
	localparam int SAMPLE_W   = 16;
	localparam int LEVEL_W    = 7;
	localparam int PHASE_W    = 32;
	localparam int TAB_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int ENTRY_W    = BYTE_W + 1;
	localparam int SUB_W      = 4;

	localparam int BYTE_SYMBOLS = 10;
	localparam logic [SUB_W-1:0] SUB_START0 = 4'd0;
	localparam logic [SUB_W-1:0] SUB_START1 = 4'd1;
	localparam logic [SUB_W-1:0] SUB_DATA   = 4'd2;
	localparam logic [SUB_W-1:0] SUB_LAST   = 4'd9;

	localparam logic [SAMPLE_W-1:0] MIDSCALE = 16'h8000;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic [INC_W-1:0] RST_INC_START_ZERO = 31'd97391549;
	localparam logic [INC_W-1:0] RST_INC_START_ONE  = 31'd194783097;
	localparam logic [INC_W-1:0] RST_INC_BIT_LOW    = 31'd97391549;
	localparam logic [INC_W-1:0] RST_INC_BIT_HIGH   = 31'd146087323;
	localparam logic [SPS_W-1:0] RST_SPS            = 16'd441;
	localparam logic [AMP_W-1:0] RST_AMPLITUDE      = 15'd20000;

	typedef enum logic [REQ_W-1:0] {
		REQ_BYTE    = 2'd0,
		REQ_SILENCE = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INC_START_ZERO = 3'd0,
		REG_INC_START_ONE  = 3'd1,
		REG_INC_BIT_LOW    = 3'd2,
		REG_INC_BIT_HIGH   = 3'd3,
		REG_SPS            = 3'd4,
		REG_AMPLITUDE      = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		TONE_SILENT = 3'd0,
		TONE_START0 = 3'd1,
		TONE_START1 = 3'd2,
		TONE_LOW    = 3'd3,
		TONE_HIGH   = 3'd4
	} tone_t;

	typedef struct packed {
		logic              push_byte;
		logic              push_silence;
		logic              pop;
		logic [BYTE_W-1:0] data_byte;
	} q_ctrl_t;

	typedef struct packed {
		logic  byte_room;
		logic  silence_room;
		logic  empty;
		tone_t head_tone;
	} q_stat_t;

	// quarter-wave entry k: round(32768*sin(pi/2*k/N)), Q30 Taylor series, clamped
	function automatic logic [TAB_W-1:0] sine_entry(input int k, input int abits);
		longint unsigned x;
		longint unsigned term;
		longint sum;
		longint unsigned v;
		x = (HALF_PI_Q30 * longint'(k)) >> abits;
		sum = longint'(x);
		term = x;
		for (int n = 0; n < 6; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			case (n)
				0:       term = term / 64'd6;
				1:       term = term / 64'd20;
				2:       term = term / 64'd42;
				3:       term = term / 64'd72;
				4:       term = term / 64'd110;
				default: term = term / 64'd156;
			endcase
			if ((n % 2) == 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = unsigned'(sum);
		v = ((v * 64'd32768) + (64'd1 << 29)) >> 30;
		if (v > 64'd32768) begin
			v = 64'd32768;
		end
		return v[TAB_W-1:0];
	endfunction

endpackage

/* hw/rtl/fsktm_if.sv */
`timescale 1ns / 1ps

interface fsktm_req_if;
	logic                            valid;
	logic                            ready;
	logic [fsktm_pkg::REQ_W-1:0]     req_type;
	logic [fsktm_pkg::BYTE_W-1:0]    data_byte;

	modport source (output valid, req_type, data_byte, input ready);
	modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface fsktm_res_if;
	logic                             valid;
	logic                             ready;
	logic [fsktm_pkg::SAMPLE_W-1:0]   sample;
	logic                             is_sample;
	logic                             accepted;
	logic [fsktm_pkg::LEVEL_W-1:0]    queue_level;

	modport source (output valid, sample, is_sample, accepted, queue_level, input ready);
	modport sink (input valid, sample, is_sample, accepted, queue_level, output ready);
endinterface

interface fsktm_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [fsktm_pkg::CFG_IDX_W-1:0]    index;
	logic [fsktm_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/fsktm_ram.sv */
`timescale 1ns / 1ps

module fsktm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/fsktm_sine_rom.sv */
`timescale 1ns / 1ps

module fsktm_sine_rom #(
	parameter int SINE_ADDR_BITS = fsktm_pkg::SINE_ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [SINE_ADDR_BITS:0]       idx,
	output logic [fsktm_pkg::TAB_W-1:0]   tab
);

	localparam int N = 1 << SINE_ADDR_BITS;

	typedef logic [fsktm_pkg::TAB_W-1:0] rom_t [0:N];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k <= N; k++) begin
			r[k] = fsktm_pkg::sine_entry(k, SINE_ADDR_BITS);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [fsktm_pkg::TAB_W-1:0] tab_q;

	always_ff @(posedge clk) begin
		if (en) begin
			tab_q <= ROM[idx];
		end
	end

	assign tab = tab_q;

endmodule

/* hw/rtl/fsktm_tone_queue.sv */
`timescale 1ns / 1ps

// entries are whole requests: a byte entry expands to ten symbols via sub_q
module fsktm_tone_queue #(
	parameter int QUEUE_DEPTH = fsktm_pkg::QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fsktm_pkg::q_ctrl_t  ctrl,
	output fsktm_pkg::q_stat_t  stat,
	output logic [CNT_W-1:0]    level_next
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [PTR_W-1:0]                  hp_q, tp_q, hp_next;
	logic [fsktm_pkg::SUB_W-1:0]       sub_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              byp_q;
	logic [fsktm_pkg::ENTRY_W-1:0]     byp_d_q;
	logic [fsktm_pkg::ENTRY_W-1:0]     rdata, head, wdata;
	logic                              we, entry_pop;
	logic [2:0]                        bit_idx;

	assign we    = ctrl.push_byte | ctrl.push_silence;
	assign wdata = ctrl.push_byte ? {1'b1, ctrl.data_byte} : '0;
	assign head  = byp_q ? byp_d_q : rdata;

	assign entry_pop = ctrl.pop & (~head[fsktm_pkg::BYTE_W] | (sub_q == fsktm_pkg::SUB_LAST));
	assign hp_next   = entry_pop ? ((hp_q == PTR_LAST) ? '0 : hp_q + 1'b1) : hp_q;

	fsktm_ram #(
		.WIDTH (fsktm_pkg::ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (tp_q),
		.wdata (wdata),
		.raddr (hp_next),
		.rdata (rdata)
	);

	always_comb begin
		level_next = cnt_q;
		if (ctrl.push_byte) begin
			level_next = cnt_q + CNT_W'(fsktm_pkg::BYTE_SYMBOLS);
		end else if (ctrl.push_silence) begin
			level_next = cnt_q + 1'b1;
		end else if (ctrl.pop) begin
			level_next = cnt_q - 1'b1;
		end
	end

	assign bit_idx = 3'(sub_q - fsktm_pkg::SUB_DATA);

	always_comb begin
		stat.byte_room    = ({1'b0, cnt_q} + (CNT_W+1)'(fsktm_pkg::BYTE_SYMBOLS))
			<= (CNT_W+1)'(QUEUE_DEPTH);
		stat.silence_room = cnt_q < CNT_W'(QUEUE_DEPTH);
		stat.empty        = cnt_q == '0;
		if (!head[fsktm_pkg::BYTE_W]) begin
			stat.head_tone = fsktm_pkg::TONE_SILENT;
		end else begin
			case (sub_q)
				fsktm_pkg::SUB_START0: stat.head_tone = fsktm_pkg::TONE_START0;
				fsktm_pkg::SUB_START1: stat.head_tone = fsktm_pkg::TONE_START1;
				default: stat.head_tone = head[bit_idx] ? fsktm_pkg::TONE_HIGH
					: fsktm_pkg::TONE_LOW;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q  <= '0;
			tp_q  <= '0;
			sub_q <= '0;
			cnt_q <= '0;
			byp_q <= 1'b0;
		end else begin
			hp_q  <= hp_next;
			cnt_q <= level_next;
			byp_q <= we & (tp_q == hp_next);
			if (we) begin
				tp_q <= (tp_q == PTR_LAST) ? '0 : tp_q + 1'b1;
			end
			if (ctrl.pop) begin
				sub_q <= entry_pop ? '0 : sub_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_d_q <= wdata;
	end

endmodule

/* hw/rtl/byte_fsk_tone_modulator.sv */
`timescale 1ns / 1ps

// channel  dir  payload                                   transaction
// cfg      in   index[2:0], data[30:0]                    register write, always ready
// req      in   req_type[1:0], data_byte[7:0]             one request
// res      out  sample[15:0], is_sample, accepted,        one result per request
//               queue_level[6:0]
//
// One request per cycle while req.ready is high; each result is registered first at the sine
// ROM read, then again after the multiply and offset, in the output register.
// Queue and phase state update at the edge the request is taken.
// res.ready low holds the output register; req.ready drops only when both stages are full.
// arst_n clears control state and loads the register defaults; no clearing pass.
module byte_fsk_tone_modulator #(
	parameter int QUEUE_DEPTH    = fsktm_pkg::QUEUE_DEPTH_DEF,
	parameter int SINE_ADDR_BITS = fsktm_pkg::SINE_ADDR_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	fsktm_cfg_if.sink   cfg,
	fsktm_req_if.sink   req,
	fsktm_res_if.source res
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [SINE_ADDR_BITS:0] QTAB_N = (SINE_ADDR_BITS+1)'(1) << SINE_ADDR_BITS;

	logic [fsktm_pkg::INC_W-1:0]    inc_start_zero_q, inc_start_one_q;
	logic [fsktm_pkg::INC_W-1:0]    inc_bit_low_q, inc_bit_high_q;
	logic [fsktm_pkg::SPS_W-1:0]    sps_q;
	logic [fsktm_pkg::AMP_W-1:0]    amp_q;

	fsktm_pkg::tone_t               cur_q, tone_sel;
	logic [fsktm_pkg::SPS_W-1:0]    cnt_q;
	logic [fsktm_pkg::PHASE_W-1:0]  ph_q, ph_use;
	logic [fsktm_pkg::INC_W-1:0]    inc_sel;

	fsktm_pkg::q_ctrl_t             q_ctrl;
	fsktm_pkg::q_stat_t             q_stat;
	logic [CNT_W-1:0]               level_next;

	logic in_fire, is_byte, is_sil, is_tick, boundary, accepted;
	logic adv1, adv2;
	logic [SINE_ADDR_BITS-1:0]      tab_addr;
	logic [SINE_ADDR_BITS:0]        tab_idx;
	logic [fsktm_pkg::TAB_W-1:0]    tab_s1;

	logic                           v_s1, is_sample_s1, accepted_s1, audible_s1, neg_s1;
	logic [fsktm_pkg::LEVEL_W-1:0]  level_s1;

	logic                           v_s2, is_sample_s2, accepted_s2;
	logic [fsktm_pkg::SAMPLE_W-1:0] sample_s2, sample_d;
	logic [fsktm_pkg::LEVEL_W-1:0]  level_s2;
	logic [30:0]                    prod;
	logic [fsktm_pkg::SAMPLE_W-1:0] mag;

	// config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_start_zero_q <= fsktm_pkg::RST_INC_START_ZERO;
			inc_start_one_q  <= fsktm_pkg::RST_INC_START_ONE;
			inc_bit_low_q    <= fsktm_pkg::RST_INC_BIT_LOW;
			inc_bit_high_q   <= fsktm_pkg::RST_INC_BIT_HIGH;
			sps_q            <= fsktm_pkg::RST_SPS;
			amp_q            <= fsktm_pkg::RST_AMPLITUDE;
		end else if (cfg.valid) begin
			case (cfg.index)
				fsktm_pkg::REG_INC_START_ZERO: inc_start_zero_q <= cfg.data;
				fsktm_pkg::REG_INC_START_ONE:  inc_start_one_q  <= cfg.data;
				fsktm_pkg::REG_INC_BIT_LOW:    inc_bit_low_q    <= cfg.data;
				fsktm_pkg::REG_INC_BIT_HIGH:   inc_bit_high_q   <= cfg.data;
				fsktm_pkg::REG_SPS:            sps_q <= cfg.data[fsktm_pkg::SPS_W-1:0];
				fsktm_pkg::REG_AMPLITUDE:      amp_q <= cfg.data[fsktm_pkg::AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// request decode
	assign adv2      = ~v_s2 | res.ready;
	assign adv1      = ~v_s1 | adv2;
	assign req.ready = adv1;
	assign in_fire   = req.valid & adv1;

	assign is_byte = req.req_type == fsktm_pkg::REQ_BYTE;
	assign is_sil  = req.req_type == fsktm_pkg::REQ_SILENCE;
	assign is_tick = req.req_type == fsktm_pkg::REQ_TICK;

	assign boundary = cnt_q >= sps_q;
	assign tone_sel = boundary ? (q_stat.empty ? fsktm_pkg::TONE_SILENT : q_stat.head_tone)
		: cur_q;
	assign ph_use   = boundary ? '0 : ph_q;

	always_comb begin
		case (tone_sel)
			fsktm_pkg::TONE_START0: inc_sel = inc_start_zero_q;
			fsktm_pkg::TONE_START1: inc_sel = inc_start_one_q;
			fsktm_pkg::TONE_LOW:    inc_sel = inc_bit_low_q;
			fsktm_pkg::TONE_HIGH:   inc_sel = inc_bit_high_q;
			default:                inc_sel = '0;
		endcase
	end

	always_comb begin
		q_ctrl.push_byte    = in_fire & is_byte & q_stat.byte_room;
		q_ctrl.push_silence = in_fire & is_sil & q_stat.silence_room;
		q_ctrl.pop          = in_fire & is_tick & boundary & ~q_stat.empty;
		q_ctrl.data_byte    = req.data_byte;
	end

	always_comb begin
		case (req.req_type)
			fsktm_pkg::REQ_BYTE:    accepted = q_stat.byte_room;
			fsktm_pkg::REQ_SILENCE: accepted = q_stat.silence_room;
			fsktm_pkg::REQ_TICK:    accepted = 1'b1;
			default:                accepted = 1'b0;
		endcase
	end

	fsktm_tone_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (q_ctrl),
		.stat       (q_stat),
		.level_next (level_next)
	);

	// symbol timing and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= fsktm_pkg::TONE_SILENT;
			cnt_q <= '0;
			ph_q  <= '0;
		end else if (in_fire && is_tick) begin
			cur_q <= tone_sel;
			ph_q  <= ph_use + fsktm_pkg::PHASE_W'(inc_sel);
			if (boundary) begin
				cnt_q <= fsktm_pkg::SPS_W'(1);
			end else if (cnt_q != '1) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// quarter-wave lookup
	assign tab_addr = ph_use[fsktm_pkg::PHASE_W-3 -: SINE_ADDR_BITS];
	assign tab_idx  = ph_use[fsktm_pkg::PHASE_W-2] ? (QTAB_N - {1'b0, tab_addr})
		: {1'b0, tab_addr};

	fsktm_sine_rom #(
		.SINE_ADDR_BITS (SINE_ADDR_BITS)
	) u_rom (
		.clk (clk),
		.en  (in_fire),
		.idx (tab_idx),
		.tab (tab_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			is_sample_s1 <= is_tick;
			accepted_s1  <= accepted;
			audible_s1   <= tone_sel != fsktm_pkg::TONE_SILENT;
			neg_s1       <= ph_use[fsktm_pkg::PHASE_W-1];
			level_s1     <= fsktm_pkg::LEVEL_W'(level_next);
		end
	end

	// scale and offset
	assign prod = {16'b0, amp_q} * {15'b0, tab_s1};
	assign mag  = prod[30:15];

	always_comb begin
		if (!is_sample_s1) begin
			sample_d = '0;
		end else if (!audible_s1) begin
			sample_d = fsktm_pkg::MIDSCALE;
		end else if (neg_s1) begin
			sample_d = fsktm_pkg::MIDSCALE - mag;
		end else begin
			sample_d = fsktm_pkg::MIDSCALE + mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			sample_s2    <= sample_d;
			is_sample_s2 <= is_sample_s1;
			accepted_s2  <= accepted_s1;
			level_s2     <= level_s1;
		end
	end

	assign res.valid       = v_s2;
	assign res.sample      = sample_s2;
	assign res.is_sample   = is_sample_s2;
	assign res.accepted    = accepted_s2;
	assign res.queue_level = level_s2;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import fsktm_pkg::*;

	localparam int TAB_BITS    = SINE_ADDR_BITS_DEF;
	localparam int TAB_N       = 1 << TAB_BITS;
	localparam int QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [INC_W-1:0] INC_MAX = '1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                is_sample;
		logic                accepted;
		logic [LEVEL_W-1:0]  queue_level;
	} fsk_result_t;

	class fsk_tone_model;
		bit [INC_W-1:0] inc_start0, inc_start1, inc_low, inc_high;
		bit [SPS_W-1:0] sps;
		bit [AMP_W-1:0] amp;
		tone_t          tones[$];
		tone_t          cur_tone;
		bit [SPS_W-1:0] sym_count;
		bit [PHASE_W-1:0] phase;
		bit [TAB_W-1:0] qtab[0:TAB_N];
		fsk_result_t    pending[$];
		int unsigned    errors;

		function new();
			longint unsigned x, term, v;
			longint sum;
			for (int k = 0; k <= TAB_N; k++) begin
				x = (HALF_PI_Q30 * longint'(k)) / TAB_N;
				sum = longint'(x);
				term = x;
				for (int n = 1; n <= 6; n++) begin
					term = (term * x) >> 30;
					term = (term * x) >> 30;
					term = term / longint'((2 * n) * (2 * n + 1));
					if (n % 2 == 1) begin
						sum = sum - longint'(term);
					end else begin
						sum = sum + longint'(term);
					end
				end
				if (sum < 0) begin
					sum = 0;
				end
				v = (longint'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
				if (v > 64'd32768) begin
					v = 64'd32768;
				end
				qtab[k] = v[TAB_W-1:0];
			end
			inc_start0 = RST_INC_START_ZERO;
			inc_start1 = RST_INC_START_ONE;
			inc_low    = RST_INC_BIT_LOW;
			inc_high   = RST_INC_BIT_HIGH;
			sps        = RST_SPS;
			amp        = RST_AMPLITUDE;
			cur_tone   = TONE_SILENT;
			sym_count  = '0;
			phase      = '0;
			errors     = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] v);
			case (idx)
				REG_INC_START_ZERO: inc_start0 = v;
				REG_INC_START_ONE:  inc_start1 = v;
				REG_INC_BIT_LOW:    inc_low = v;
				REG_INC_BIT_HIGH:   inc_high = v;
				REG_SPS:            sps = v[SPS_W-1:0];
				REG_AMPLITUDE:      amp = v[AMP_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [INC_W-1:0] tone_inc(tone_t code);
			case (code)
				TONE_START0: return inc_start0;
				TONE_START1: return inc_start1;
				TONE_LOW:    return inc_low;
				TONE_HIGH:   return inc_high;
				default:     return '0;
			endcase
		endfunction

		function void accept_request(req_t r, bit [BYTE_W-1:0] b);
			fsk_result_t e;
			bit [TAB_BITS-1:0] addr;
			bit [TAB_W-1:0] t;
			bit [31:0] mag;
			e = '0;
			case (r)
				REQ_BYTE: begin
					if (QDEPTH - tones.size() >= BYTE_SYMBOLS) begin
						tones.push_back(TONE_START0);
						tones.push_back(TONE_START1);
						for (int i = 0; i < BYTE_W; i++) begin
							tones.push_back(b[i] ? TONE_HIGH : TONE_LOW);
						end
						e.accepted = 1'b1;
					end
				end
				REQ_SILENCE: begin
					if (tones.size() < QDEPTH) begin
						tones.push_back(TONE_SILENT);
						e.accepted = 1'b1;
					end
				end
				REQ_TICK: begin
					if (sym_count >= sps) begin
						sym_count = '0;
						phase = '0;
						if (tones.size() == 0) begin
							cur_tone = TONE_SILENT;
						end else begin
							cur_tone = tones.pop_front();
						end
					end
					if (cur_tone == TONE_SILENT) begin
						e.sample = MIDSCALE;
					end else begin
						addr = phase[29 -: TAB_BITS];
						t = phase[30] ? qtab[TAB_N - addr] : qtab[addr];
						mag = (32'(amp) * 32'(t)) >> 15;
						e.sample = phase[31] ? MIDSCALE - mag[15:0] : MIDSCALE + mag[15:0];
					end
					phase = phase + 32'(tone_inc(cur_tone));
					if (sym_count != '1) begin
						sym_count++;
					end
					e.is_sample = 1'b1;
					e.accepted = 1'b1;
				end
				default: ;
			endcase
			e.queue_level = LEVEL_W'(tones.size());
			pending.push_back(e);
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10) begin
				$display("mismatch: %s", msg);
			end
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				note_error($sformatf("%s expected %0d, got %0d", name, want, got));
			end
		endfunction

		function void compare_result(fsk_result_t got);
			fsk_result_t want;
			if (pending.size() == 0) begin
				note_error($sformatf("unexpected transaction: sample %0d level %0d",
					got.sample, got.queue_level));
				return;
			end
			want = pending.pop_front();
			check_field("sample", want.sample, got.sample);
			check_field("is_sample", want.is_sample, got.is_sample);
			check_field("accepted", want.accepted, got.accepted);
			check_field("queue_level", want.queue_level, got.queue_level);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit send_burst;
	bit recv_burst;
	int unsigned cycle_count;
	fsk_tone_model tone_model;

	fsktm_cfg_if cfg_ch();
	fsktm_req_if req_ch();
	fsktm_res_if res_ch();

	byte_fsk_tone_modulator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.res(res_ch)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout");
			$display("byte_fsk_tone_modulator regression: fail");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = v;
		do @(posedge clk); while (!cfg_ch.ready);
		tone_model.write_reg(idx, v);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_tones(logic [INC_W-1:0] i0, logic [INC_W-1:0] i1,
			logic [INC_W-1:0] i2, logic [INC_W-1:0] i3,
			logic [SPS_W-1:0] sps, logic [AMP_W-1:0] amp);
		write_reg(REG_INC_START_ZERO, i0);
		write_reg(REG_INC_START_ONE, i1);
		write_reg(REG_INC_BIT_LOW, i2);
		write_reg(REG_INC_BIT_HIGH, i3);
		write_reg(REG_SPS, CFG_DATA_W'(sps));
		write_reg(REG_AMPLITUDE, CFG_DATA_W'(amp));
	endtask

	task automatic send_req(req_t r, logic [BYTE_W-1:0] b);
		int gap;
		if ($urandom_range(0, 31) == 0) begin
			send_burst = !send_burst;
		end
		gap = send_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.req_type = r;
		req_ch.data_byte = b;
		do @(posedge clk); while (!req_ch.ready);
		tone_model.accept_request(r, b);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (tone_model.pending.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_random(int items, int tick_pct);
		int done;
		int roll;
		req_t r;
		done = 0;
		while (done < items) begin
			if ($urandom_range(0, 49) == 0) begin
				wait_drained();
			end
			roll = $urandom_range(0, 99);
			if (roll < tick_pct) begin
				r = REQ_TICK;
			end else if (roll >= 95) begin
				r = REQ_NONE;
			end else if (roll % 3 != 0) begin
				r = REQ_BYTE;
			end else begin
				r = REQ_SILENCE;
			end
			send_req(r, BYTE_W'($urandom_range(0, 255)));
			if (r != REQ_NONE) begin
				done++;
			end
		end
	endtask

	task automatic collect_results();
		fsk_result_t got;
		int stall;
		forever begin
			if ($urandom_range(0, 31) == 0) begin
				recv_burst = !recv_burst;
			end
			stall = recv_burst ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			got.sample = res_ch.sample;
			got.is_sample = res_ch.is_sample;
			got.accepted = res_ch.accepted;
			got.queue_level = res_ch.queue_level;
			tone_model.compare_result(got);
			@(negedge clk);
		end
	endtask

	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		collect_results();
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_INC_START_ZERO;
		cfg_ch.data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_NONE;
		req_ch.data_byte = '0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		cycle_count = 0;
		tone_model = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: silent until the first symbol boundary
		send_req(REQ_TICK, 8'h00);
		send_req(REQ_TICK, 8'hFF);
		send_req(REQ_NONE, 8'hA5);
		send_req(REQ_BYTE, 8'h00);
		send_req(REQ_TICK, 8'h5A);
		wait_drained();

		// default tones, short symbols; then fill the queue to the brim
		write_reg(REG_SPS, CFG_DATA_W'(2));
		send_req(REQ_BYTE, 8'hFF);
		send_req(REQ_SILENCE, 8'h00);
		repeat (6) send_req(REQ_TICK, BYTE_W'($urandom_range(0, 255)));
		while (tone_model.tones.size() + BYTE_SYMBOLS <= QDEPTH) begin
			send_req(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
		end
		send_req(REQ_BYTE, 8'h3C);
		while (tone_model.tones.size() < QDEPTH) begin
			send_req(REQ_SILENCE, 8'hFF);
		end
		send_req(REQ_SILENCE, 8'h00);
		send_req(REQ_NONE, 8'hFF);

		wait_drained();
		set_tones(INC_MAX, INC_MAX, INC_MAX, INC_MAX, 16'd1, 15'h7FFF);
		run_random(95, 70);

		wait_drained();
		set_tones('0, '0, '0, '0, 16'd0, 15'd0);
		run_random(80, 60);

		wait_drained();
		set_tones(INC_W'($urandom), INC_W'($urandom), INC_W'($urandom), INC_W'($urandom),
			16'd8, AMP_W'($urandom));
		run_random(95, 75);

		// symbol length cut below the running count
		wait_drained();
		write_reg(REG_SPS, CFG_DATA_W'(2));
		run_random(95, 65);

		wait_drained();
		set_tones(RST_INC_START_ZERO, RST_INC_START_ONE, RST_INC_BIT_LOW, RST_INC_BIT_HIGH,
			SPS_W'($urandom_range(1, 5)), 15'h7FFF);
		run_random(95, 60);

		wait_drained();
		set_tones(INC_W'($urandom), INC_W'($urandom), INC_W'($urandom), INC_W'($urandom),
			16'hFFFF, AMP_W'($urandom));
		run_random(40, 50);

		wait_drained();
		write_reg(REG_SPS, CFG_DATA_W'(1));
		write_reg(REG_AMPLITUDE, CFG_DATA_W'(AMP_W'($urandom)));
		run_random(95, 80);

		wait_drained();
		set_tones(INC_W'($urandom), INC_W'($urandom), INC_W'($urandom), INC_W'($urandom),
			SPS_W'($urandom_range(1, 6)), AMP_W'($urandom));
		run_random(160, 70);

		wait_drained();
		repeat (10) @(posedge clk);
		if (tone_model.errors == 0 && tone_model.pending.size() == 0) begin
			$display("byte_fsk_tone_modulator regression: pass");
		end else begin
			$display("byte_fsk_tone_modulator regression: fail");
		end
		$finish;
	end

endmodule

/* byte_fsk_tone_modulator.f */
hw/rtl/fsktm_pkg.sv
hw/rtl/fsktm_if.sv
hw/rtl/fsktm_ram.sv
hw/rtl/fsktm_sine_rom.sv
hw/rtl/fsktm_tone_queue.sv
hw/rtl/byte_fsk_tone_modulator.sv
dv/testbench.sv
